@@ rtl/vde_pkg.sv @@
// ============================================================================
// vde_pkg
// Shared types, constants and float32 arithmetic of the vector distance engine.
// ============================================================================
`default_nettype none

package vde_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int CNT_W       = $clog2(MAX_DIM + 2);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int SQRT_STEPS  = 25;
    localparam int DIV_STEPS   = 26;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam logic [31:0] F_ONE     = 32'h3F80_0000;
    localparam logic [31:0] F_NEG_ONE = 32'hBF80_0000;
    localparam logic [31:0] F_EPS     = 32'h3400_0000;
    localparam logic [31:0] F_NAN     = 32'h7FC0_0000;
    localparam logic [30:0] F_INF_MAG = 31'h7F80_0000;

    localparam logic [2:0] MET_NEG_DOT = 3'd0;
    localparam logic [2:0] MET_L2_SQ   = 3'd1;
    localparam logic [2:0] MET_L2      = 3'd2;
    localparam logic [2:0] MET_COSINE  = 3'd3;
    localparam logic [2:0] MET_L1      = 3'd4;
    localparam logic [2:0] MET_HAMMING = 3'd5;
    localparam logic [2:0] METRIC_RST  = MET_L2_SQ;

    typedef struct packed {
        logic [31:0] a_value;
        logic [31:0] b_value;
        logic        last;
        logic [2:0]  metric;
        logic        neq;
    } vde_item_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } vde_iter_op_t;

    typedef struct packed {
        logic         start;
        vde_iter_op_t op;
        logic [31:0]  x;
        logic [31:0]  y;
    } vde_iter_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } vde_iter_rsp_t;

    typedef enum logic [1:0] {
        IT_IDLE,
        IT_NORM,
        IT_RUN,
        IT_RND
    } vde_iter_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_C0,
        BK_C1,
        BK_C2,
        BK_C3,
        BK_FIN,
        BK_WSQ,
        BK_WSA,
        BK_WSB,
        BK_CHK,
        BK_WDV,
        BK_OUT
    } vde_back_state_t;

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    // value = m * 2^(e - 150), rounded to nearest even
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [12:0] e,
                                             input logic [49:0] m);
        logic [5:0]         p;
        logic signed [12:0] be;
        logic signed [12:0] s;
        logic [63:0]        mw;
        logic [63:0]        mask;
        logic [23:0]        mant;
        logic               g;
        logic               st;
        logic [24:0]        mr;
        logic [12:0]        eb;
        logic [37:0]        tot;
        logic [31:0]        r;
        begin
            p = '0;
            for (int i = 0; i < 50; i++) begin
                if (m[i]) begin
                    p = 6'(i);
                end
            end
            be = e + $signed({7'b0, p}) - 13'sd23;
            s  = (be >= 13'sd1) ? ($signed({7'b0, p}) - 13'sd23) : (13'sd1 - e);
            mw = {14'b0, m};
            if (s <= 13'sd0) begin
                mw   = mw << 6'(-s);
                mant = mw[23:0];
                g    = 1'b0;
                st   = 1'b0;
            end else begin
                if (s > 13'sd63) begin
                    s = 13'sd63;
                end
                mask = (64'd1 << s[5:0]) - 64'd1;
                mant = 24'(mw >> s[5:0]);
                g    = |(mw & mask & ~(mask >> 1));
                st   = |(mw & (mask >> 1));
            end
            mr  = {1'b0, mant} + 25'(g & (st | mant[0]));
            eb  = (be >= 13'sd1) ? 13'(be - 13'sd1) : 13'd0;
            tot = {2'b0, eb, 23'b0} + {13'b0, mr};
            if (m == 50'd0) begin
                r = {sgn, 31'd0};
            end else if (tot >= {7'b0, F_INF_MAG}) begin
                r = {sgn, F_INF_MAG};
            end else begin
                r = {sgn, tot[30:0]};
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sg;
        logic        inf_a;
        logic        inf_b;
        logic        zero_a;
        logic        zero_b;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] pr;
        logic [31:0] r;
        begin
            sg     = a[31] ^ b[31];
            inf_a  = (a[30:0] == F_INF_MAG);
            inf_b  = (b[30:0] == F_INF_MAG);
            zero_a = (a[30:0] == 31'd0);
            zero_b = (b[30:0] == 31'd0);
            ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
            eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
            ma     = {a[30:23] != 8'd0, a[22:0]};
            mb     = {b[30:23] != 8'd0, b[22:0]};
            pr     = ma * mb;
            if (is_nan(a) || is_nan(b) || (inf_a && zero_b) || (inf_b && zero_a)) begin
                r = F_NAN;
            end else if (inf_a || inf_b) begin
                r = {sg, F_INF_MAG};
            end else begin
                r = fp_round(sg, $signed({5'b0, ea}) + $signed({5'b0, eb}) - 13'sd150,
                             {2'b0, pr});
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [26:0] xm;
        logic [26:0] yw;
        logic [26:0] ys;
        logic        st;
        logic [27:0] sum;
        logic [31:0] r;
        begin
            if (b[30:0] > a[30:0]) begin
                x = b;
                y = a;
            end else begin
                x = a;
                y = b;
            end
            ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
            ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
            d  = ex - ey;
            xm = {x[30:23] != 8'd0, x[22:0], 3'b0};
            yw = {y[30:23] != 8'd0, y[22:0], 3'b0};
            if (d >= 8'd27) begin
                ys = '0;
                st = (yw != 27'd0);
            end else begin
                ys = yw >> d;
                st = |(yw & ((27'd1 << d) - 27'd1));
            end
            ys  = ys | {26'b0, st};
            sum = (x[31] == y[31]) ? ({1'b0, xm} + {1'b0, ys}) : ({1'b0, xm} - {1'b0, ys});
            if (is_nan(a) || is_nan(b)) begin
                r = F_NAN;
            end else if (x[30:0] == F_INF_MAG) begin
                r = ((y[30:0] == F_INF_MAG) && (x[31] != y[31])) ? F_NAN : x;
            end else if (sum == 28'd0) begin
                r = {x[31] & y[31], 31'd0};
            end else begin
                r = fp_round(x[31], $signed({5'b0, ex}) - 13'sd3, {22'b0, sum});
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/vde_if.sv @@
// ============================================================================
// vde_if
// Item channels of the vector distance engine: element pairs in, distances out.
// ============================================================================
`default_nettype none

interface vde_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic        last;
    modport source (output valid, output a_value, output b_value, output last, input ready);
    modport sink (input valid, input a_value, input b_value, input last, output ready);
endinterface

interface vde_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance;
    logic        too_long;
    modport source (output valid, output distance, output too_long, input ready);
    modport sink (input valid, input distance, input too_long, output ready);
endinterface

`default_nettype wire

@@ rtl/vde_front.sv @@
// ============================================================================
// vde_front
// Accepts element pairs, tags each with metric and mismatch, and queues them.
// ============================================================================
`default_nettype none

module vde_front
    import vde_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    vde_in_if.sink         in_ch,
    input  wire logic [2:0] metric,
    output vde_item_t      item,
    output logic           item_valid,
    input  wire logic      item_pop
);

    vde_item_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QPTR_W:0]      count_reg;
    logic [QPTR_W:0]      count_next;
    logic                 push;
    logic                 pop;
    logic                 equal;
    vde_item_t            new_item;

    assign in_ch.ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = item_pop && item_valid;
    assign item_valid  = (count_reg != '0);
    assign item        = queue_reg[rd_ptr_reg];

    assign equal = !is_nan(in_ch.a_value) && !is_nan(in_ch.b_value)
                   && ((in_ch.a_value == in_ch.b_value)
                       || ((in_ch.a_value[30:0] == 31'd0) && (in_ch.b_value[30:0] == 31'd0)));

    always_comb
    begin
        new_item.a_value = in_ch.a_value;
        new_item.b_value = in_ch.b_value;
        new_item.last    = in_ch.last;
        new_item.metric  = metric;
        new_item.neq     = !equal;
        wr_ptr_next      = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next      = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next       = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vde_iter.sv @@
// ============================================================================
// vde_iter
// Iterative float32 square root and divide, one result bit per cycle.
// ============================================================================
`default_nettype none

module vde_iter
    import vde_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vde_iter_req_t req,
    output vde_iter_rsp_t      rsp
);

    vde_iter_state_t    state_reg;
    vde_iter_state_t    state_next;
    vde_iter_op_t       op_reg;
    vde_iter_op_t       op_next;
    logic               sgn_reg;
    logic               sgn_next;
    logic [24:0]        man_reg;
    logic [24:0]        man_next;
    logic signed [9:0]  exp_reg;
    logic signed [9:0]  exp_next;
    logic [23:0]        my_reg;
    logic [23:0]        my_next;
    logic signed [9:0]  ey_reg;
    logic signed [9:0]  ey_next;
    logic signed [12:0] er_reg;
    logic signed [12:0] er_next;
    logic [50:0]        rem_reg;
    logic [50:0]        rem_next;
    logic [50:0]        res_reg;
    logic [50:0]        res_next;
    logic [50:0]        bit_reg;
    logic [50:0]        bit_next;
    logic [STEP_W-1:0]  cnt_reg;
    logic [STEP_W-1:0]  cnt_next;
    logic [31:0]        result_reg;
    logic [31:0]        result_next;
    logic               done_reg;
    logic               done_next;

    logic [7:0]         xe;
    logic [7:0]         ye;
    logic               x_nan;
    logic               y_nan;
    logic               x_inf;
    logic               y_inf;
    logic               x_zero;
    logic               y_zero;
    logic               qs;
    logic [24:0]        mm;
    logic [50:0]        trial;

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

    assign xe     = req.x[30:23];
    assign ye     = req.y[30:23];
    assign x_nan  = is_nan(req.x);
    assign y_nan  = is_nan(req.y);
    assign x_inf  = (req.x[30:0] == F_INF_MAG);
    assign y_inf  = (req.y[30:0] == F_INF_MAG);
    assign x_zero = (req.x[30:0] == 31'd0);
    assign y_zero = (req.y[30:0] == 31'd0);
    assign qs     = req.x[31] ^ req.y[31];
    assign mm     = exp_reg[0] ? {man_reg[23:0], 1'b0} : man_reg;
    assign trial  = res_reg + bit_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        sgn_next    = sgn_reg;
        man_next    = man_reg;
        exp_next    = exp_reg;
        my_next     = my_reg;
        ey_next     = ey_reg;
        er_next     = er_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            IT_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    man_next = {1'b0, xe != 8'd0, req.x[22:0]};
                    exp_next = (xe == 8'd0) ? -10'sd126 : $signed({2'b0, xe}) - 10'sd127;
                    my_next  = {1'b1, req.y[22:0]};
                    ey_next  = $signed({2'b0, ye}) - 10'sd127;
                    if (req.op == OP_SQRT)
                    begin
                        sgn_next = 1'b0;
                        priority if (x_nan || (req.x[31] && !x_zero))
                        begin
                            result_next = F_NAN;
                            done_next   = 1'b1;
                        end
                        else if (x_inf || x_zero)
                        begin
                            result_next = req.x;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = IT_NORM;
                        end
                    end
                    else
                    begin
                        sgn_next = qs;
                        priority if (x_nan || y_nan || (x_inf && y_inf) || (x_zero && y_zero))
                        begin
                            result_next = F_NAN;
                            done_next   = 1'b1;
                        end
                        else if (y_inf || x_zero)
                        begin
                            result_next = {qs, 31'd0};
                            done_next   = 1'b1;
                        end
                        else if (x_inf || y_zero)
                        begin
                            result_next = {qs, F_INF_MAG};
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = IT_NORM;
                        end
                    end
                end
            end
            IT_NORM:
            begin
                if (!man_reg[23])
                begin
                    man_next = {man_reg[23:0], 1'b0};
                    exp_next = exp_reg - 10'sd1;
                end
                else
                begin
                    res_next   = '0;
                    state_next = IT_RUN;
                    if (op_reg == OP_SQRT)
                    begin
                        er_next  = 13'((exp_reg - $signed({9'b0, exp_reg[0]})) >>> 1) + 13'sd125;
                        rem_next = {1'b0, mm, 25'b0};
                        bit_next = 51'd1 << 48;
                        cnt_next = STEP_W'(SQRT_STEPS);
                    end
                    else
                    begin
                        er_next  = 13'(exp_reg) - 13'(ey_reg) + 13'sd124;
                        rem_next = {26'b0, man_reg};
                        cnt_next = STEP_W'(DIV_STEPS);
                    end
                end
            end
            IT_RUN:
            begin
                if (op_reg == OP_SQRT)
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_next = rem_reg - trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                else
                begin
                    if (rem_reg >= {27'b0, my_reg})
                    begin
                        rem_next = (rem_reg - {27'b0, my_reg}) << 1;
                        res_next = {res_reg[49:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_reg << 1;
                        res_next = {res_reg[49:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    state_next = IT_RND;
                end
            end
            IT_RND:
            begin
                result_next = fp_round(sgn_reg, er_reg, {res_reg[48:0], rem_reg != 51'd0});
                done_next   = 1'b1;
                state_next  = IT_IDLE;
            end
            default:
            begin
                state_next = IT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IT_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sgn_reg    <= sgn_next;
        man_reg    <= man_next;
        exp_reg    <= exp_next;
        my_reg     <= my_next;
        ey_reg     <= ey_next;
        er_reg     <= er_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

@@ rtl/vde_back.sv @@
// ============================================================================
// vde_back
// Accumulates element pairs with one float multiplier and one float adder,
// finishes the selected distance and holds it in the output register.
// ============================================================================
`default_nettype none

module vde_back
    import vde_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vde_item_t     item,
    input  wire logic          item_valid,
    output logic               item_pop,
    output vde_iter_req_t      iter_req,
    input  wire vde_iter_rsp_t iter_rsp,
    vde_out_if.source          out_ch
);

    vde_back_state_t  state_reg;
    vde_back_state_t  state_next;
    vde_item_t        cur_reg;
    vde_item_t        cur_next;
    logic [31:0]      na_reg;
    logic [31:0]      na_next;
    logic [31:0]      nb_reg;
    logic [31:0]      nb_next;
    logic [31:0]      main_reg;
    logic [31:0]      main_next;
    logic [CNT_W-1:0] mis_reg;
    logic [CNT_W-1:0] mis_next;
    logic [CNT_W-1:0] el_reg;
    logic [CNT_W-1:0] el_next;
    logic [31:0]      m_reg;
    logic [31:0]      m_next;
    logic [31:0]      d_reg;
    logic [31:0]      d_next;
    logic [31:0]      sa_reg;
    logic [31:0]      sa_next;
    logic [31:0]      res_reg;
    logic [31:0]      res_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      dist_reg;
    logic [31:0]      dist_next;
    logic             too_long_reg;
    logic             too_long_next;

    logic [31:0]      mul_x;
    logic [31:0]      mul_y;
    logic [31:0]      add_x;
    logic [31:0]      add_y;
    logic [31:0]      mul_r;
    logic [31:0]      add_r;
    logic [31:0]      sim_c;
    logic             den_small;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.distance = dist_reg;
    assign out_ch.too_long = too_long_reg;

    assign mul_r = fp_mul(mul_x, mul_y);
    assign add_r = fp_add(add_x, add_y);

    assign den_small = !is_nan(m_reg) && (m_reg[31] || (m_reg[30:0] < F_EPS[30:0]));

    always_comb
    begin
        sim_c = iter_rsp.result;
        if (!is_nan(iter_rsp.result) && (iter_rsp.result[30:0] > F_ONE[30:0]))
        begin
            sim_c = iter_rsp.result[31] ? F_NEG_ONE : F_ONE;
        end
    end

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        add_x = '0;
        add_y = '0;
        unique case (state_reg)
            BK_C0:
            begin
                mul_x = cur_reg.a_value;
                mul_y = cur_reg.a_value;
                add_x = cur_reg.a_value;
                add_y = {~cur_reg.b_value[31], cur_reg.b_value[30:0]};
            end
            BK_C1:
            begin
                mul_x = cur_reg.b_value;
                mul_y = cur_reg.b_value;
                add_x = na_reg;
                add_y = m_reg;
            end
            BK_C2:
            begin
                if ((cur_reg.metric == MET_NEG_DOT) || (cur_reg.metric == MET_COSINE))
                begin
                    mul_x = cur_reg.a_value;
                    mul_y = cur_reg.b_value;
                end
                else
                begin
                    mul_x = d_reg;
                    mul_y = d_reg;
                end
                add_x = nb_reg;
                add_y = m_reg;
            end
            BK_C3:
            begin
                add_x = main_reg;
                add_y = (cur_reg.metric == MET_L1) ? {1'b0, d_reg[30:0]} : m_reg;
            end
            BK_WSB:
            begin
                mul_x = sa_reg;
                mul_y = iter_rsp.result;
            end
            BK_WDV:
            begin
                add_x = F_ONE;
                add_y = {~sim_c[31], sim_c[30:0]};
            end
            default:
            begin
                mul_x = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        main_next      = main_reg;
        mis_next       = mis_reg;
        el_next        = el_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        sa_next        = sa_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        dist_next      = dist_reg;
        too_long_next  = too_long_reg;
        item_pop       = 1'b0;
        iter_req.start = 1'b0;
        iter_req.op    = OP_SQRT;
        iter_req.x     = main_reg;
        iter_req.y     = m_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    cur_next   = item;
                    state_next = BK_C0;
                end
            end
            BK_C0:
            begin
                m_next = mul_r;
                d_next = add_r;
                if (cur_reg.neq && (mis_reg <= CNT_W'(MAX_DIM)))
                begin
                    mis_next = mis_reg + 1'b1;
                end
                if (el_reg <= CNT_W'(MAX_DIM))
                begin
                    el_next = el_reg + 1'b1;
                end
                state_next = BK_C1;
            end
            BK_C1:
            begin
                na_next    = add_r;
                m_next     = mul_r;
                state_next = BK_C2;
            end
            BK_C2:
            begin
                nb_next    = add_r;
                m_next     = mul_r;
                state_next = BK_C3;
            end
            BK_C3:
            begin
                if (cur_reg.metric <= MET_L1)
                begin
                    main_next = add_r;
                end
                state_next = cur_reg.last ? BK_FIN : BK_IDLE;
            end
            BK_FIN:
            begin
                state_next = BK_OUT;
                unique case (cur_reg.metric)
                    MET_NEG_DOT: res_next = {~main_reg[31], main_reg[30:0]};
                    MET_L2_SQ:   res_next = main_reg;
                    MET_L1:      res_next = main_reg;
                    MET_HAMMING: res_next = fp_round(1'b0, 13'sd150, 50'(mis_reg));
                    MET_L2:
                    begin
                        iter_req.start = 1'b1;
                        state_next     = BK_WSQ;
                    end
                    MET_COSINE:
                    begin
                        iter_req.start = 1'b1;
                        iter_req.x     = na_reg;
                        state_next     = BK_WSA;
                    end
                    default:     res_next = '0;
                endcase
            end
            BK_WSQ:
            begin
                if (iter_rsp.done)
                begin
                    res_next   = iter_rsp.result;
                    state_next = BK_OUT;
                end
            end
            BK_WSA:
            begin
                if (iter_rsp.done)
                begin
                    sa_next        = iter_rsp.result;
                    iter_req.start = 1'b1;
                    iter_req.x     = nb_reg;
                    state_next     = BK_WSB;
                end
            end
            BK_WSB:
            begin
                if (iter_rsp.done)
                begin
                    m_next     = mul_r;
                    state_next = BK_CHK;
                end
            end
            BK_CHK:
            begin
                if (den_small)
                begin
                    res_next   = F_ONE;
                    state_next = BK_OUT;
                end
                else
                begin
                    iter_req.start = 1'b1;
                    iter_req.op    = OP_DIV;
                    state_next     = BK_WDV;
                end
            end
            BK_WDV:
            begin
                if (iter_rsp.done)
                begin
                    res_next   = add_r;
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    dist_next      = is_nan(res_reg) ? F_NAN : res_reg;
                    too_long_next  = (el_reg > CNT_W'(MAX_DIM));
                    na_next        = '0;
                    nb_next        = '0;
                    main_next      = '0;
                    mis_next       = '0;
                    el_next        = '0;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            na_reg        <= '0;
            nb_reg        <= '0;
            main_reg      <= '0;
            mis_reg       <= '0;
            el_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            na_reg        <= na_next;
            nb_reg        <= nb_next;
            main_reg      <= main_next;
            mis_reg       <= mis_next;
            el_reg        <= el_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        m_reg        <= m_next;
        d_reg        <= d_next;
        sa_reg       <= sa_next;
        res_reg      <= res_next;
        dist_reg     <= dist_next;
        too_long_reg <= too_long_next;
    end

endmodule

`default_nettype wire

@@ rtl/vector_distance_engine.sv @@
// ============================================================================
// vector_distance_engine
// Streaming float32 distance between two vectors, one element pair per item.
//
// in_ch carries a_value, b_value and last; each accepted item adds one
// element pair. The item with last set closes the vectors and yields one
// item on out_ch: distance (float32) and too_long. cfg_we/cfg_wdata write
// the metric: 0 neg dot, 1 squared L2, 2 L2, 3 cosine, 4 L1, 5 mismatches.
// A four-entry queue decouples input acceptance from the arithmetic.
// Each pair is popped in the idle state, then takes four steps (C0 to C3)
// on one float multiplier and one float adder shared over the pair's
// products and sums; the next pair is popped only after those steps.
// A last pair's result then passes the FIN and OUT states for metrics
// 0, 1, 4, 5; metric 2 adds a square root, metric 3 adds two square
// roots and, unless the denominator is below F_EPS, a divide.
// The bit-serial unit normalizes a subnormal operand by shifts in its
// NORM state; zero, infinite and NaN operands finish without iterating.
// Reset clears the sums, counts and queue and sets the metric to 1.
// A stalled out_ch holds the result register; the next vector keeps
// accumulating and waits only when its own result is ready.
// ============================================================================
`default_nettype none

module vector_distance_engine
    import vde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    vde_in_if.sink          in_ch,
    vde_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_wdata
);

    logic [2:0]    metric_reg;
    logic [2:0]    metric_next;
    vde_item_t     item;
    logic          item_valid;
    logic          item_pop;
    vde_iter_req_t iter_req;
    vde_iter_rsp_t iter_rsp;

    assign metric_next = cfg_we ? cfg_wdata : metric_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_RST;
        end
        else
        begin
            metric_reg <= metric_next;
        end
    end

    vde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .metric     (metric_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    vde_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iter_req),
        .rsp   (iter_rsp)
    );

    vde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .iter_req   (iter_req),
        .iter_rsp   (iter_rsp),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ============================================================================
// tb
// Self-checking bench for vector_distance_engine: table-driven directed
// vectors, then random vectors under three handshake idle profiles; typed
// rows are scored on table distances, the rest on a float32 nearest-even predictor.
// ============================================================================
`default_nettype none

module tb;
    import vde_pkg::*;

    localparam logic [2:0] MET_SPARE6 = 3'd6;
    localparam logic [2:0] MET_SPARE7 = 3'd7;
    localparam int         DRAIN_CYCLES = 200;
    localparam int         STALL_LIMIT  = 20000;
    localparam int         RAND_ITEMS   = 525;

    typedef struct packed {
        logic        cfg_on;
        logic [2:0]  cfg_val;
        logic [31:0] a;
        logic [31:0] b;
        logic        last;
        logic        typed;
        logic [31:0] exp_dist;
    } stim_row_t;

    localparam int N_ROWS = 23;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        '{1'b0, MET_L2_SQ,   32'h4040_0000, 32'h3F80_0000, 1'b1, 1'b1, 32'h4080_0000},
        '{1'b1, MET_NEG_DOT, 32'h4000_0000, 32'h4040_0000, 1'b1, 1'b1, 32'hC0C0_0000},
        '{1'b0, MET_NEG_DOT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{1'b1, MET_L2,      32'h4080_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h4080_0000},
        '{1'b1, MET_COSINE,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h3F80_0000},
        '{1'b0, MET_COSINE,  32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b0, MET_COSINE,  32'h3F80_0000, 32'hBF80_0000, 1'b1, 1'b1, 32'h4000_0000},
        '{1'b0, MET_COSINE,  32'h4040_0000, 32'h3F00_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, MET_COSINE,  32'h7F7F_FFFF, 32'h0080_0000, 1'b1, 1'b0, 32'h0},
        '{1'b1, MET_L1,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h7FC0_0000},
        '{1'b0, MET_L1,      32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1, 1'b1, 32'h7F80_0000},
        '{1'b0, MET_L1,      32'h0000_0001, 32'h8000_0003, 1'b1, 1'b0, 32'h0},
        '{1'b1, MET_HAMMING, 32'h7FC0_0000, 32'h7FC0_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, MET_HAMMING, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{1'b0, MET_HAMMING, 32'h3F80_0000, 32'h4000_0000, 1'b1, 1'b1, 32'h4000_0000},
        '{1'b1, MET_SPARE6,  32'h3F80_0000, 32'h4000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b1, MET_SPARE7,  32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b1, MET_L1,      32'h4000_0000, 32'h3F80_0000, 1'b0, 1'b0, 32'h0},
        '{1'b1, MET_L2_SQ,   32'h4040_0000, 32'h3F80_0000, 1'b1, 1'b1, 32'h40A0_0000},
        '{1'b0, MET_L2_SQ,   32'h0000_0001, 32'h8000_0001, 1'b1, 1'b0, 32'h0},
        '{1'b1, MET_NEG_DOT, 32'h7F80_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FC0_0000},
        '{1'b0, MET_NEG_DOT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{1'b1, MET_COSINE,  32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1, 32'h3F80_0000}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;

    vde_in_if  in_ch ();
    vde_out_if out_ch ();

    vector_distance_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    logic [31:0] sum_main;
    logic [31:0] sum_norm_a;
    logic [31:0] sum_norm_b;
    int          pairs_unequal;
    int          pairs_seen;
    logic [2:0]  metric_now;

    logic [31:0] distance_q [$];
    logic        too_long_q [$];

    int  mismatches;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  rx_hold;
    int  quiet_cycles;

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic real f32_to_real(input logic [31:0] f);
        real r;
        begin
            if (f[30:23] == 8'hFF) begin
                if (f[22:0] != 23'd0) begin
                    r = $bitstoreal(64'h7FF8_0000_0000_0000);
                end else begin
                    r = $bitstoreal({f[31], 11'h7FF, 52'd0});
                end
            end else if (f[30:23] == 8'd0) begin
                r = real'(f[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
                if (f[31]) begin
                    r = -r;
                end
            end else begin
                r = $bitstoreal({f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'd0});
            end
            return r;
        end
    endfunction

    // round a double to float32, nearest even
    function automatic logic [31:0] real_to_f32(input real r);
        logic [63:0] u;
        logic [63:0] mant;
        logic [63:0] q;
        logic [63:0] tot;
        logic        g;
        logic        st;
        int          ex;
        int          sh;
        begin
            u = $realtobits(r);
            if (u[62:52] == 11'h7FF) begin
                return (u[51:0] != 52'd0) ? F_NAN : {u[63], F_INF_MAG};
            end
            if (u[62:52] == 11'd0) begin
                return {u[63], 31'd0};
            end
            ex = int'(u[62:52]) - 1023;
            if (ex > 127) begin
                return {u[63], F_INF_MAG};
            end
            mant = {11'd0, 1'b1, u[51:0]};
            sh   = 29 + ((ex < -126) ? (-126 - ex) : 0);
            if (sh > 60) begin
                sh = 60;
            end
            q   = mant >> sh;
            g   = mant[sh - 1];
            st  = (mant & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
            q   = q + 64'(g & (st | q[0]));
            tot = ((ex >= -126) ? (64'(ex + 126) << 23) : 64'd0) + q;
            if (tot >= 64'h7F80_0000) begin
                return {u[63], F_INF_MAG};
            end
            return {u[63], tot[30:0]};
        end
    endfunction

    function automatic logic [31:0] f_mul(input logic [31:0] x, input logic [31:0] y);
        return real_to_f32(f32_to_real(x) * f32_to_real(y));
    endfunction

    function automatic logic [31:0] f_add(input logic [31:0] x, input logic [31:0] y);
        return real_to_f32(f32_to_real(x) + f32_to_real(y));
    endfunction

    function automatic logic [31:0] f_root(input logic [31:0] x);
        return real_to_f32($sqrt(f32_to_real(x)));
    endfunction

    function automatic void clear_sums();
        sum_main      = 32'd0;
        sum_norm_a    = 32'd0;
        sum_norm_b    = 32'd0;
        pairs_unequal = 0;
        pairs_seen    = 0;
    endfunction

    // advance the distance state by one pair; 1 when a distance is due
    function automatic bit distance_step(input logic [31:0] a, input logic [31:0] b,
                                         input logic last, output logic [31:0] dist_out,
                                         output logic long_flag);
        logic [31:0] diff;
        logic [31:0] denom;
        logic [31:0] sim;
        begin
            sum_norm_a = f_add(sum_norm_a, f_mul(a, a));
            sum_norm_b = f_add(sum_norm_b, f_mul(b, b));
            diff = real_to_f32(f32_to_real(a) - f32_to_real(b));
            case (metric_now)
                MET_NEG_DOT, MET_COSINE: sum_main = f_add(sum_main, f_mul(a, b));
                MET_L2_SQ, MET_L2:       sum_main = f_add(sum_main, f_mul(diff, diff));
                MET_L1:
                begin
                    sum_main = f_add(sum_main, (f32_to_real(diff) >= 0.0) ? diff
                                                   : {~diff[31], diff[30:0]});
                end
                default: ;
            endcase
            if (f32_to_real(a) != f32_to_real(b) && pairs_unequal <= MAX_DIM) begin
                pairs_unequal++;
            end
            if (pairs_seen <= MAX_DIM) begin
                pairs_seen++;
            end
            if (!last) begin
                return 1'b0;
            end
            case (metric_now)
                MET_NEG_DOT:       dist_out = {~sum_main[31], sum_main[30:0]};
                MET_L2_SQ, MET_L1: dist_out = sum_main;
                MET_L2:            dist_out = f_root(sum_main);
                MET_COSINE:
                begin
                    denom = f_mul(f_root(sum_norm_a), f_root(sum_norm_b));
                    if (f32_to_real(denom) < f32_to_real(F_EPS)) begin
                        dist_out = F_ONE;
                    end else begin
                        sim = real_to_f32(f32_to_real(sum_main) / f32_to_real(denom));
                        if (f32_to_real(sim) > 1.0) begin
                            sim = F_ONE;
                        end
                        if (f32_to_real(sim) < -1.0) begin
                            sim = F_NEG_ONE;
                        end
                        dist_out = real_to_f32(1.0 - f32_to_real(sim));
                    end
                end
                MET_HAMMING: dist_out = real_to_f32(real'(pairs_unequal));
                default:     dist_out = 32'd0;
            endcase
            if (is_nan(dist_out)) begin
                dist_out = F_NAN;
            end
            long_flag = (pairs_seen > MAX_DIM);
            clear_sums();
            return 1'b1;
        end
    endfunction

    task automatic wait_drained();
        while (distance_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_metric(input logic [2:0] m);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we     <= 1'b0;
        metric_now = m;
    endtask

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input logic last,
                             input bit typed, input logic [31:0] typed_dist);
        logic [31:0] dist_val;
        logic        long_flag;
        begin
            while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.a_value <= a;
            in_ch.b_value <= b;
            in_ch.last    <= last;
            @(posedge clk);
            while (!in_ch.ready) begin
                @(posedge clk);
            end
            if (distance_step(a, b, last, dist_val, long_flag)) begin
                distance_q.push_back(typed ? typed_dist : dist_val);
                too_long_q.push_back(typed ? 1'b0 : long_flag);
            end
        end
    endtask

    function automatic logic [31:0] pick_element(input logic [31:0] other);
        logic [31:0] v;
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4, 5:
                    v = {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
                6:  v = $urandom;
                7:  v = {1'($urandom), 8'd0, 23'($urandom)};
                8:
                begin
                    case ($urandom_range(0, 5))
                        0:       v = 32'h0000_0000;
                        1:       v = 32'h8000_0000;
                        2:       v = {1'($urandom), F_INF_MAG};
                        3:       v = {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
                        4:       v = {1'($urandom), 31'h7F7F_FFFF};
                        default: v = {1'($urandom), 31'h0080_0000};
                    endcase
                end
                9:  v = {1'($urandom), 8'($urandom_range(90, 160)), 23'($urandom)};
                default: v = other;
            endcase
            return v;
        end
    endfunction

    task automatic send_vector(input int len, input bool_mid_cfg);
        logic [31:0] a;
        for (int i = 0; i < len; i++) begin
            if (bool_mid_cfg && !rx_hold && i == len / 2 && len > 1) begin
                in_ch.valid <= 1'b0;
                write_metric(3'($urandom_range(0, 7)));
            end
            a = pick_element(32'd0);
            send_pair(a, pick_element(a), i == len - 1, 1'b0, 32'd0);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !rx_hold && !(rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct);
            if (out_ch.valid && out_ch.ready) begin
                if (distance_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: distance=%h too_long=%b",
                                 out_ch.distance, out_ch.too_long);
                    end
                end else begin
                    if (out_ch.distance !== distance_q[0] || out_ch.too_long !== too_long_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: distance exp %h got %h, too_long exp %b got %b",
                                     distance_q[0], out_ch.distance, too_long_q[0],
                                     out_ch.too_long);
                        end
                    end
                    void'(distance_q.pop_front());
                    void'(too_long_q.pop_front());
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int len;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 3'd0;
        in_ch.valid   = 1'b0;
        in_ch.a_value = 32'd0;
        in_ch.b_value = 32'd0;
        in_ch.last    = 1'b0;
        out_ch.ready  = 1'b0;
        mismatches    = 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rx_hold       = 1'b0;
        quiet_cycles  = 0;
        metric_now    = METRIC_RST;
        clear_sums();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED[r].cfg_on) begin
                in_ch.valid <= 1'b0;
                write_metric(DIRECTED[r].cfg_val);
            end
            send_pair(DIRECTED[r].a, DIRECTED[r].b, DIRECTED[r].last,
                      DIRECTED[r].typed, DIRECTED[r].exp_dist);
        end

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 59 : 0;
            rx_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 24 : 0;
            if (phase == 2) begin
                rx_hold = 1'b1;
                fork
                    begin
                        repeat (400) @(posedge clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            sent = 0;
            while (sent < RAND_ITEMS / 3) begin
                if (!rx_hold && $urandom_range(0, 3) == 0) begin
                    in_ch.valid <= 1'b0;
                    write_metric(3'($urandom_range(0, 7)));
                end
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 8);
                send_vector(len, $urandom_range(0, 29) == 0);
                sent += len;
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
